[sv/lmsi_pkg.sv]
// Shared types and constants for the LMS linear identifier.
`default_nettype none
package lmsi_pkg;

	localparam int SAMPLE_W      = 24;
	localparam int WEIGHT_W      = 32;
	localparam int STEP_W        = 16;
	localparam int SAMPLE_INPUTS = 4;
	localparam int IN_W          = 144;
	localparam int OUT_W         = 96;
	localparam int PRED_PROD_W   = 56;
	localparam int TOT_W         = 64;

	localparam logic [STEP_W-1:0]   STEP_RESET = 16'd6554;
	localparam logic [SAMPLE_W-1:0] ONE_Q12    = 24'd4096;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFFFFFF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h80000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_PWAIT,
		ST_OUT,
		ST_ESTEP,
		ST_EWAIT,
		ST_UPD,
		ST_UWAIT
	} state_t;

	typedef enum logic [1:0] {
		OP_PRED,
		OP_ESTEP,
		OP_UPD_LO,
		OP_UPD_HI
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic first;
		logic last;
		logic load_in;
		logic load_out;
	} cmd_t;

endpackage
`default_nettype wire

[sv/lmsi_datapath.sv]
// Datapath: weight store, shared multiplier pipeline, accumulator and update arithmetic.
`default_nettype none
module lmsi_datapath import lmsi_pkg::*; #(
	parameter int REGRESSOR_COUNT = 5,
	parameter int OUTPUT_COUNT    = 2,
	localparam int WD  = REGRESSOR_COUNT * OUTPUT_COUNT,
	localparam int WIW = $clog2(WD),
	localparam int RIW = $clog2(REGRESSOR_COUNT),
	localparam int OIW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [WIW-1:0]   widx,
	input  wire logic [RIW-1:0]   ridx,
	input  wire logic [OIW-1:0]   oidx,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             cfg_wr_en,
	input  wire logic [STEP_W-1:0] cfg_wr_data,
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  busy
);

	localparam int ACC_W = PRED_PROD_W + $clog2(REGRESSOR_COUNT);

	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] reg_in [REGRESSOR_COUNT];
	logic [SAMPLE_W-1:0] regs_q [REGRESSOR_COUNT];
	logic [SAMPLE_W-1:0] tgt0_q, tgt1_q;
	logic [SAMPLE_W-1:0] pred_q [OUTPUT_COUNT];
	logic [SAMPLE_W-1:0] err_q  [OUTPUT_COUNT];
	logic [39:0]         es_q   [OUTPUT_COUNT];
	logic [WEIGHT_W-1:0] mem_q  [WD];
	logic [WD-1:0]       wvalid_q;
	logic [OUT_W-1:0]    out_q;

	// stage 1: operand fetch
	logic                v_s1, first_s1, last_s1, rdv_s1;
	op_t                 op_s1;
	logic [OIW-1:0]      oidx_s1;
	logic [WIW-1:0]      widx_s1;
	logic [WEIGHT_W-1:0] rd_s1;
	logic [SAMPLE_W-1:0] r_s1;
	// stage 2: multiply
	logic                v_s2, first_s2, last_s2;
	op_t                 op_s2;
	logic [OIW-1:0]      oidx_s2;
	logic [WIW-1:0]      widx_s2;
	logic [WEIGHT_W-1:0] w_s2;
	logic signed [57:0]  prod_s2;
	// stage 3: accumulate / combine
	logic                v_s3, last_s3;
	op_t                 op_s3;
	logic [OIW-1:0]      oidx_s3;
	logic [WIW-1:0]      widx_s3;
	logic [WEIGHT_W-1:0] w_s3;
	logic [TOT_W-1:0]    tot_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic [44:0]         lo_q;
	// stage 4: prediction done
	logic                fin_s4;
	logic [OIW-1:0]      oidx_s4;

	logic [WEIGHT_W-1:0] wt;
	logic signed [32:0]  mul_a;
	logic signed [24:0]  mul_b;
	logic [39:0]         es_sel;
	logic signed [ACC_W-1:0] prod_ext, acc_rnd, acc_sh;
	logic [SAMPLE_W-1:0] pred_sat;
	logic [SAMPLE_W-1:0] tgt_sel;
	logic [24:0]         diff;
	logic [SAMPLE_W-1:0] err_sat;
	logic [39:0]         delta;
	logic [40:0]         wsum;
	logic [WEIGHT_W-1:0] wnew;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	// regressor and target capture on input transfer
	for (genvar gi = 0; gi < REGRESSOR_COUNT; gi++) begin : g_reg
		if (gi == 0) begin : g_bias
			assign reg_in[gi] = ONE_Q12;
		end else if (gi <= SAMPLE_INPUTS) begin : g_sample
			assign reg_in[gi] = s_tdata[(gi-1)*SAMPLE_W +: SAMPLE_W];
		end else begin : g_zero
			assign reg_in[gi] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			regs_q <= reg_in;
			tgt0_q <= s_tdata[4*SAMPLE_W +: SAMPLE_W];
			tgt1_q <= s_tdata[5*SAMPLE_W +: SAMPLE_W];
		end
	end

	// weight store: registered read, write from stage 3
	always_ff @(posedge clk) begin
		if (v_s3 && op_s3 == OP_UPD_HI) begin
			mem_q[widx_s3] <= wnew;
		end
		rd_s1 <= mem_q[widx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			if (v_s3 && op_s3 == OP_UPD_HI) begin
				wvalid_q[widx_s3] <= 1'b1;
			end
			rdv_s1 <= wvalid_q[widx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			fin_s4 <= 1'b0;
		end else begin
			v_s1   <= cmd.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			fin_s4 <= v_s3 && op_s3 == OP_PRED && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= cmd.op;
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		oidx_s1  <= oidx;
		widx_s1  <= widx;
		r_s1     <= regs_q[ridx];

		op_s2    <= op_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		oidx_s2  <= oidx_s1;
		widx_s2  <= widx_s1;
		w_s2     <= wt;
		prod_s2  <= mul_a * mul_b;

		op_s3    <= op_s2;
		last_s3  <= last_s2;
		oidx_s3  <= oidx_s2;
		widx_s3  <= widx_s2;
		w_s3     <= w_s2;
		oidx_s4  <= oidx_s3;
	end

	assign wt     = rdv_s1 ? rd_s1 : '0;
	assign es_sel = es_q[oidx_s1];

	always_comb begin
		mul_b = {r_s1[SAMPLE_W-1], r_s1};
		case (op_s1)
			OP_PRED: begin
				mul_a = {wt[WEIGHT_W-1], wt};
			end
			OP_ESTEP: begin
				mul_a = {{9{err_q[oidx_s1][SAMPLE_W-1]}}, err_q[oidx_s1]};
				mul_b = {9'd0, step_q};
			end
			OP_UPD_LO: begin
				mul_a = {13'd0, es_sel[19:0]};
			end
			OP_UPD_HI: begin
				mul_a = {{13{es_sel[39]}}, es_sel[39:20]};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign prod_ext = ACC_W'($signed(prod_s2[PRED_PROD_W-1:0]));

	always_ff @(posedge clk) begin
		if (v_s2) begin
			case (op_s2)
				OP_PRED: begin
					acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
				end
				OP_ESTEP: begin
					es_q[oidx_s2] <= prod_s2[39:0];
				end
				OP_UPD_LO: begin
					lo_q <= prod_s2[44:0];
				end
				OP_UPD_HI: begin
					tot_s3 <= (TOT_W'($signed(prod_s2[43:0])) << 20)
						+ TOT_W'($signed(lo_q)) + TOT_W'(1 << 23);
				end
				default: begin
				end
			endcase
		end
	end

	// prediction: round half up to Q.12, saturate
	assign acc_rnd = acc_q + ACC_W'(1 << 15);
	assign acc_sh  = acc_rnd >>> 16;
	assign pred_sat = (&acc_sh[ACC_W-1:SAMPLE_W-1] || ~|acc_sh[ACC_W-1:SAMPLE_W-1])
		? acc_sh[SAMPLE_W-1:0] : (acc_sh[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

	always_ff @(posedge clk) begin
		if (v_s3 && op_s3 == OP_PRED && last_s3) begin
			pred_q[oidx_s3] <= pred_sat;
		end
	end

	// error against target; outputs without a target use zero
	always_comb begin
		if (oidx_s4 == OIW'(0)) begin
			tgt_sel = tgt0_q;
		end else if (oidx_s4 == OIW'(1)) begin
			tgt_sel = tgt1_q;
		end else begin
			tgt_sel = '0;
		end
	end

	assign diff    = {tgt_sel[SAMPLE_W-1], tgt_sel}
		- {pred_q[oidx_s4][SAMPLE_W-1], pred_q[oidx_s4]};
	assign err_sat = (diff[24] != diff[23]) ? (diff[24] ? SAMPLE_MIN : SAMPLE_MAX)
		: diff[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (fin_s4) begin
			err_q[oidx_s4] <= err_sat;
		end
	end

	// weight update: round half up to Q.16, saturate
	assign delta = tot_s3[TOT_W-1:24];
	assign wsum  = {{9{w_s3[WEIGHT_W-1]}}, w_s3} + {delta[39], delta};
	assign wnew  = (&wsum[40:WEIGHT_W-1] || ~|wsum[40:WEIGHT_W-1]) ? wsum[WEIGHT_W-1:0]
		: (wsum[40] ? WEIGHT_MIN : WEIGHT_MAX);

	// result register
	if (OUTPUT_COUNT > 1) begin : g_out2
		always_ff @(posedge clk) begin
			if (cmd.load_out) begin
				out_q <= {err_q[1], err_q[0], pred_q[1], pred_q[0]};
			end
		end
	end else begin : g_out1
		always_ff @(posedge clk) begin
			if (cmd.load_out) begin
				out_q <= {{SAMPLE_W{1'b0}}, err_q[0], {SAMPLE_W{1'b0}}, pred_q[0]};
			end
		end
	end

	assign m_tdata = out_q;
	assign busy    = v_s1 | v_s2 | v_s3 | fin_s4;

endmodule
`default_nettype wire

[sv/lmsi_ctrl.sv]
// Controller: sequences prediction, error scaling and weight update passes.
`default_nettype none
module lmsi_ctrl import lmsi_pkg::*; #(
	parameter int REGRESSOR_COUNT = 5,
	parameter int OUTPUT_COUNT    = 2,
	localparam int WD  = REGRESSOR_COUNT * OUTPUT_COUNT,
	localparam int WIW = $clog2(WD),
	localparam int RIW = $clog2(REGRESSOR_COUNT),
	localparam int OIW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire logic           pipe_busy,
	output cmd_t                cmd,
	output logic [WIW-1:0]      widx,
	output logic [RIW-1:0]      ridx,
	output logic [OIW-1:0]      oidx
);

	state_t         state_q, state_d;
	logic [RIW-1:0] i_q;
	logic [OIW-1:0] k_q;
	logic           hi_q;
	logic           m_tvalid_q;
	logic           i_end, k_end, out_free;

	assign i_end    = i_q == RIW'(REGRESSOR_COUNT - 1);
	assign k_end    = k_q == OIW'(OUTPUT_COUNT - 1);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_PRED;
			ST_PRED:  if (i_end && k_end) state_d = ST_PWAIT;
			ST_PWAIT: if (!pipe_busy) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_ESTEP;
			ST_ESTEP: if (k_end) state_d = ST_EWAIT;
			ST_EWAIT: if (!pipe_busy) state_d = ST_UPD;
			ST_UPD:   if (hi_q && i_end && k_end) state_d = ST_UWAIT;
			ST_UWAIT: if (!pipe_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_PRED;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_PRED: begin
				cmd.valid = 1'b1;
				cmd.first = i_q == '0;
				cmd.last  = i_end;
			end
			ST_OUT: begin
				cmd.load_out = out_free;
			end
			ST_ESTEP: begin
				cmd.valid = 1'b1;
				cmd.op    = OP_ESTEP;
			end
			ST_UPD: begin
				cmd.valid = 1'b1;
				cmd.op    = hi_q ? OP_UPD_HI : OP_UPD_LO;
			end
			default: begin
			end
		endcase
	end

	assign widx     = WIW'(WIW'(i_q) * WIW'(OUTPUT_COUNT) + WIW'(k_q));
	assign ridx     = i_q;
	assign oidx     = k_q;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			k_q        <= '0;
			hi_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_PRED, ST_UPD: begin
					if (state_q == ST_UPD) begin
						hi_q <= !hi_q;
					end
					if (state_q == ST_PRED || hi_q) begin
						if (i_end) begin
							i_q <= '0;
							k_q <= k_end ? '0 : k_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				ST_ESTEP: begin
					k_q <= k_end ? '0 : k_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten before transfer");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pipe_busy)
		else $error("input accepted while pipeline busy");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_PRED && i_q == '0 && k_q == '0))
		else $error("prediction pass did not start from index zero");

	a_upd_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UWAIT) |-> !hi_q)
		else $error("update pass ended mid pair");

endmodule
`default_nettype wire

[sv/lms_linear_identifier.sv]
// Top level of the LMS linear identifier: controller and datapath.
//
// Input stream s_*: one transfer carries six samples; the block predicts
// both outputs from its current weights, returns prediction and error on
// the output stream m_*, then adapts all weights by step*error*regressor.
// Items are handled one at a time; s_tready is high only between items.
// The work per item is set by the single shared 33x25 multiplier, with
// R regressors and O outputs: R*O products for prediction, O for error
// scaling, two per weight for update. The result is loaded into the
// output register once the prediction pass has left the pipeline; it
// holds there until taken. If the receiver stalls, the block finishes
// the current prediction pass and waits before the error scaling and
// update passes until the output register is free.
// cfg_wr_en/cfg_wr_data write step_size (Q0.16); write only while idle.
// Reset clears all weights to zero (per-entry valid bits, no clearing
// pass), sets step_size to 6554 and empties the pipeline and output.
`default_nettype none
module lms_linear_identifier import lmsi_pkg::*; #(
	parameter int REGRESSOR_COUNT = 5,
	parameter int OUTPUT_COUNT    = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// state_sample_0, state_sample_1, drive_sample_0, drive_sample_1, target_0, target_1
	input  wire logic [IN_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// prediction_0, prediction_1, error_0, error_1
	output logic [OUT_W-1:0]       m_tdata,
	input  wire logic              cfg_wr_en,
	input  wire logic [STEP_W-1:0] cfg_wr_data
);

	localparam int WD  = REGRESSOR_COUNT * OUTPUT_COUNT;
	localparam int WIW = $clog2(WD);
	localparam int RIW = $clog2(REGRESSOR_COUNT);
	localparam int OIW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;

	cmd_t           cmd;
	logic [WIW-1:0] widx;
	logic [RIW-1:0] ridx;
	logic [OIW-1:0] oidx;
	logic           pipe_busy;

	lmsi_ctrl #(
		.REGRESSOR_COUNT(REGRESSOR_COUNT),
		.OUTPUT_COUNT   (OUTPUT_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.pipe_busy(pipe_busy),
		.cmd      (cmd),
		.widx     (widx),
		.ridx     (ridx),
		.oidx     (oidx)
	);

	lmsi_datapath #(
		.REGRESSOR_COUNT(REGRESSOR_COUNT),
		.OUTPUT_COUNT   (OUTPUT_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.widx       (widx),
		.ridx       (ridx),
		.oidx       (oidx),
		.s_tdata    (s_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.m_tdata    (m_tdata),
		.busy       (pipe_busy)
	);

endmodule
`default_nettype wire
